>>> hdl/tece_pkg.sv
// Package for the terminal escape and cursor engine: byte codes, command codes,
// the operation word that travels from the front end to the back end, and limits.
// No dependencies; the front end, queue, back end and top level import it.
package tece_pkg;

  // Screen limits that the effective column and row counts are clamped to.
  localparam int MAX_COLUMNS = 127;
  localparam int MAX_ROWS    = 63;

  // Reset values of the configuration registers.
  localparam logic [6:0] RESET_COLUMNS = 7'd100;
  localparam logic [5:0] RESET_ROWS    = 6'd37;

  // Depth of the operation queue between front end and back end.
  localparam int OP_QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WRAP_DISABLED = 2'd0;
  localparam logic [1:0] CFG_COLUMNS       = 2'd1;
  localparam logic [1:0] CFG_ROWS          = 2'd2;

  // Byte codes.
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_PAREN_L   = 8'h28;
  localparam logic [7:0] CH_PAREN_R   = 8'h29;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_B   = 8'h42;
  localparam logic [7:0] CH_UPPER_C   = 8'h43;
  localparam logic [7:0] CH_UPPER_D   = 8'h44;
  localparam logic [7:0] CH_UPPER_H   = 8'h48;
  localparam logic [7:0] CH_UPPER_J   = 8'h4A;
  localparam logic [7:0] CH_UPPER_K   = 8'h4B;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_BRACKET_L = 8'h5B;
  localparam logic [7:0] GLYPH_FIRST  = 8'h20;
  localparam logic [7:0] GLYPH_END    = 8'h7F;

  typedef enum logic [1:0] {
    ESC_TEXT    = 2'd0,
    ESC_ESC     = 2'd1,
    ESC_BRACKET = 2'd2,
    ESC_CHARSET = 2'd3
  } esc_state_t;

  typedef enum logic [2:0] {
    ACT_GLYPH        = 3'd0,
    ACT_CLEAR_ROW    = 3'd1,
    ACT_ERASE_RIGHT  = 3'd2,
    ACT_CLEAR_SCREEN = 3'd3,
    ACT_IDENTIFY     = 3'd4,
    ACT_ERROR_LAMP   = 3'd5,
    ACT_TOGGLE_LAMP  = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    OP_BS     = 4'd0,
    OP_LF     = 4'd1,
    OP_CR     = 4'd2,
    OP_PRINT  = 4'd3,
    OP_UP     = 4'd4,
    OP_DOWN   = 4'd5,
    OP_RIGHT  = 4'd6,
    OP_LEFT   = 4'd7,
    OP_HOME   = 4'd8,
    OP_CLEAR  = 4'd9,
    OP_ERASE  = 4'd10,
    OP_IDENT  = 4'd11,
    OP_ERROR  = 4'd12,
    OP_TOGGLE = 4'd13,
    OP_NONE   = 4'd14
  } op_kind_t;

  // One classified byte, as handed from the front end to the back end.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] code;      // the byte itself, used by the print path
    logic [7:0] home_col;  // zero-based target column of a cursor position
    logic [7:0] home_row;  // zero-based target row of a cursor position
  } op_t;

  // One display command.
  typedef struct packed {
    action_t    action;
    logic [6:0] column;
    logic [5:0] physical_row;
    logic [6:0] glyph_code;
    logic       last;
  } result_t;

  // A configuration write beat.
  typedef struct packed {
    logic       en;
    logic [1:0] index;
    logic [6:0] data;
  } cfg_write_t;

endpackage

>>> hdl/tece_if.sv
// Channel interfaces of the terminal escape and cursor engine: input bytes,
// display commands and configuration writes, each with valid and ready.
// No dependencies.
interface tece_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface tece_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] column;
  logic [5:0] physical_row;
  logic [6:0] glyph_code;
  logic       last;

  modport source (output valid, output action, output column, output physical_row,
                  output glyph_code, output last, input ready);
  modport sink   (input valid, input action, input column, input physical_row,
                  input glyph_code, input last, output ready);
endinterface

interface tece_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/tece_front.sv
// Front end: escape-sequence state machine and decimal parameter parsing.
// Turns each accepted byte into one operation for the back end. Uses tece_pkg.
module tece_front import tece_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  output logic       push_valid,
  output op_t        push_op,
  input  logic       push_ready
);

  esc_state_t state, state_next;
  logic [7:0] acc, acc_next;
  logic [7:0] first_param, first_param_next;

  logic        accept;
  logic        is_digit;
  logic [7:0]  digit;
  logic [11:0] acc_grown;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit    = in_byte - CH_ZERO;
  assign acc_grown = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, digit[3:0]};

  // Next state and parameter registers.
  always_comb begin
    state_next       = state;
    acc_next         = acc;
    first_param_next = first_param;
    unique case (state)
      ESC_TEXT: begin
        if (in_byte == CH_ESC) state_next = ESC_ESC;
      end
      ESC_ESC: begin
        if (in_byte == CH_BRACKET_L) begin
          state_next       = ESC_BRACKET;
          acc_next         = '0;
          first_param_next = '0;
        end else if (in_byte == CH_PAREN_L || in_byte == CH_PAREN_R) begin
          state_next = ESC_CHARSET;
        end else begin
          state_next = ESC_TEXT;
        end
      end
      ESC_BRACKET: begin
        if (is_digit) begin
          acc_next = (acc_grown > 12'd255) ? 8'd255 : acc_grown[7:0];
        end else if (in_byte == CH_SEMI) begin
          first_param_next = acc;
          acc_next         = '0;
        end else begin
          state_next = ESC_TEXT;
          if (in_byte == CH_UPPER_H || in_byte == CH_UPPER_J || in_byte == CH_UPPER_K)
            acc_next = '0;
        end
      end
      ESC_CHARSET: begin
        state_next = ESC_TEXT;
      end
      default: state_next = ESC_TEXT;
    endcase
  end

  // Operation produced by the byte. A byte that only moves the escape state still
  // goes out as OP_NONE, because the back end runs its bottom-row check on every
  // byte; that check fires when the row count has shrunk below the cursor row.
  always_comb begin
    push_op.kind     = OP_NONE;
    push_op.code     = in_byte;
    push_op.home_col = (acc == '0) ? 8'd0 : acc - 8'd1;
    push_op.home_row = (first_param == '0) ? 8'd0 : first_param - 8'd1;
    unique case (state)
      ESC_TEXT: begin
        if (in_byte != CH_ESC) begin
          priority if (in_byte == CH_BS || in_byte == CH_DEL) push_op.kind = OP_BS;
          else if (in_byte == CH_LF) push_op.kind = OP_LF;
          else if (in_byte == CH_CR) push_op.kind = OP_CR;
          else push_op.kind = OP_PRINT;
        end
      end
      ESC_ESC: begin
        if (in_byte != CH_BRACKET_L && in_byte != CH_PAREN_L && in_byte != CH_PAREN_R) begin
          push_op.kind = (in_byte == CH_UPPER_Z) ? OP_IDENT : OP_ERROR;
        end
      end
      ESC_BRACKET: begin
        if (!is_digit && in_byte != CH_SEMI) begin
          priority if (in_byte == CH_UPPER_A) push_op.kind = OP_UP;
          else if (in_byte == CH_UPPER_B) push_op.kind = OP_DOWN;
          else if (in_byte == CH_UPPER_C) push_op.kind = OP_RIGHT;
          else if (in_byte == CH_UPPER_D) push_op.kind = OP_LEFT;
          else if (in_byte == CH_UPPER_H) push_op.kind = OP_HOME;
          else if (in_byte == CH_UPPER_J) push_op.kind = OP_CLEAR;
          else if (in_byte == CH_UPPER_K) push_op.kind = OP_ERASE;
          else push_op.kind = OP_TOGGLE;
        end
      end
      ESC_CHARSET: push_op.kind = OP_NONE;
      default:     push_op.kind = OP_NONE;
    endcase
  end

  assign push_valid = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ESC_TEXT;
      acc         <= '0;
      first_param <= '0;
    end else if (accept) begin
      state       <= state_next;
      acc         <= acc_next;
      first_param <= first_param_next;
    end
  end

endmodule

>>> hdl/tece_queue.sv
// Short register queue that carries operations from the front end to the back end.
// Uses tece_pkg for the operation type.
module tece_queue import tece_pkg::*; #(
  parameter int DEPTH = OP_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop_ready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[tail] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
      if (do_pop)  head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

>>> hdl/tece_back.sv
// Back end: configuration registers, cursor and scroll state, command generation
// and the output register. Takes operations from tece_queue; uses tece_pkg.
module tece_back import tece_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg_write,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_ready,
  output logic       out_valid,
  output result_t    out_res,
  input  logic       out_ready
);

  // Configuration.
  logic       wrap_disabled;
  logic [6:0] columns;
  logic [5:0] rows;
  logic [6:0] ncols;
  logic [5:0] nrows;

  // Cursor state. row and scroll are the architectural values; row_mod and
  // scroll_mod are the same values reduced modulo the row count.
  logic [8:0] col, col_next;
  logic [5:0] row, scroll, row_mod, scroll_mod;
  logic       norm;
  logic       phase;

  logic [8:0] col1;
  logic [7:0] r1;
  logic       print;
  logic       own_valid;
  result_t    own_res, clear_res, glyph_res, res0, res1, load_res;
  logic [6:0] erase_sum, glyph_sum, scroll_inc;
  logic [5:0] erase_prow, glyph_prow;
  logic       hit, glyph, tab;
  logic [5:0] r2, s2, s_norm, scroll_next;
  logic [1:0] nres;
  logic       adv, step, commit;

  assign ncols = (columns == '0) ? 7'd1 :
                 ((8'(columns) > 8'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : columns);
  assign nrows = (rows == '0) ? 6'd1 :
                 ((7'(rows) > 7'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows);

  assign erase_sum  = {1'b0, row_mod} + {1'b0, scroll_mod};
  assign erase_prow = (erase_sum >= {1'b0, nrows}) ? 6'(erase_sum - {1'b0, nrows})
                                                    : erase_sum[5:0];

  // The operation's own effect on the cursor and its own command.
  always_comb begin
    col1      = col;
    r1        = {2'b00, row};
    print     = 1'b0;
    own_valid = 1'b0;
    own_res   = '{action: ACT_IDENTIFY, column: '0, physical_row: '0,
                  glyph_code: '0, last: 1'b0};
    unique case (op.kind)
      OP_BS, OP_LEFT: begin
        if (col != '0) col1 = col - 9'd1;
      end
      OP_LF: r1 = {2'b00, row} + 8'd1;
      OP_CR: col1 = '0;
      OP_PRINT: begin
        if (col >= {2'b00, ncols}) begin
          if (!wrap_disabled) begin
            col1  = '0;
            r1    = {2'b00, row} + 8'd1;
            print = 1'b1;
          end
        end else begin
          print = 1'b1;
        end
      end
      OP_UP: begin
        if (row != '0) r1 = {2'b00, row} - 8'd1;
      end
      OP_DOWN: begin
        if (row < nrows) r1 = {2'b00, row} + 8'd1;
      end
      OP_RIGHT: begin
        if (col < {2'b00, ncols}) col1 = col + 9'd1;
      end
      OP_HOME: begin
        col1 = {1'b0, op.home_col};
        r1   = op.home_row;
      end
      OP_CLEAR: begin
        col1           = '0;
        r1             = '0;
        own_valid      = 1'b1;
        own_res.action = ACT_CLEAR_SCREEN;
      end
      OP_ERASE: begin
        if (col < {2'b00, ncols}) begin
          own_valid            = 1'b1;
          own_res.action       = ACT_ERASE_RIGHT;
          own_res.column       = col[6:0];
          own_res.physical_row = erase_prow;
        end
      end
      OP_IDENT: begin
        own_valid      = 1'b1;
        own_res.action = ACT_IDENTIFY;
      end
      OP_ERROR: begin
        own_valid      = 1'b1;
        own_res.action = ACT_ERROR_LAMP;
      end
      OP_TOGGLE: begin
        own_valid      = 1'b1;
        own_res.action = ACT_TOGGLE_LAMP;
      end
      default: own_valid = 1'b0;
    endcase
  end

  // Scrolling when the cursor leaves the bottom row.
  assign hit         = (r1 >= {2'b00, nrows});
  assign r2          = hit ? nrows - 6'd1 : r1[5:0];
  assign scroll_inc  = {1'b0, scroll} + 7'd1;
  assign s2          = (scroll_inc >= {1'b0, nrows}) ? '0 : scroll_inc[5:0];
  assign s_norm      = hit ? s2 : scroll_mod;
  assign scroll_next = hit ? s2 : scroll;

  assign clear_res = '{action: ACT_CLEAR_ROW, column: '0,
                       physical_row: (s2 == '0) ? nrows - 6'd1 : s2 - 6'd1,
                       glyph_code: '0, last: 1'b0};

  // Print path: tab stop or glyph at the (possibly wrapped) cursor.
  assign tab   = print && (op.code == CH_TAB);
  assign glyph = print && (op.code >= GLYPH_FIRST) && (op.code < GLYPH_END);
  assign glyph_sum  = {1'b0, r2} + {1'b0, s_norm};
  assign glyph_prow = (glyph_sum >= {1'b0, nrows}) ? 6'(glyph_sum - {1'b0, nrows})
                                                    : glyph_sum[5:0];
  assign glyph_res = '{action: ACT_GLYPH, column: col1[6:0], physical_row: glyph_prow,
                       glyph_code: op.code[6:0], last: 1'b0};

  always_comb begin
    col_next = col1;
    if (tab)        col_next = {col1[8:3] + 6'd1, 3'b000};
    else if (glyph) col_next = col1 + 9'd1;
  end

  // Commands in order: own command, clear row, glyph.
  assign nres = 2'(own_valid) + 2'(hit) + 2'(glyph);
  assign res0 = own_valid ? own_res : (hit ? clear_res : glyph_res);
  assign res1 = (own_valid && hit) ? clear_res : glyph_res;

  // The command loaded into the output register, with its last flag.
  always_comb begin
    load_res      = phase ? res1 : res0;
    load_res.last = phase || (nres == 2'd1);
  end

  assign adv      = !out_valid || out_ready;
  assign step     = op_valid && !norm && ((nres == 2'd0) || adv);
  assign commit   = step && ((nres != 2'd2) || phase);
  assign op_ready = commit;

  always_ff @(posedge clk) begin
    if (step && nres != 2'd0) out_res <= load_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_disabled <= 1'b0;
      columns       <= RESET_COLUMNS;
      rows          <= RESET_ROWS;
      col           <= '0;
      row           <= '0;
      scroll        <= '0;
      row_mod       <= '0;
      scroll_mod    <= '0;
      norm          <= 1'b0;
      phase         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (step && nres != 2'd0) out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;

      if (step && nres == 2'd2) phase <= !phase;

      if (cfg_write.en) begin
        unique case (cfg_write.index)
          CFG_WRAP_DISABLED: wrap_disabled <= cfg_write.data[0];
          CFG_COLUMNS:       columns <= cfg_write.data;
          CFG_ROWS: begin
            rows       <= cfg_write.data[5:0];
            row_mod    <= row;
            scroll_mod <= scroll;
            norm       <= 1'b1;
          end
          default: ;
        endcase
      end else if (norm) begin
        // One subtraction per cycle, unless a configuration write comes, until both are below the row count.
        if (row_mod >= nrows)    row_mod <= row_mod - nrows;
        if (scroll_mod >= nrows) scroll_mod <= scroll_mod - nrows;
        if (row_mod < nrows && scroll_mod < nrows) norm <= 1'b0;
      end else if (commit) begin
        col        <= col_next;
        row        <= r2;
        scroll     <= scroll_next;
        row_mod    <= r2;
        scroll_mod <= s_norm;
      end
    end
  end

endmodule

>>> hdl/terminal_escape_cursor_engine.sv
// Top level of the terminal escape and cursor engine: front end, operation queue
// and back end. Depends on tece_pkg, tece_if, tece_front, tece_queue and tece_back.
//
//   channel  direction  beat carries                                       accepted when
//   chars    in         char_byte                                          valid && ready
//   cmds     out        action, column, physical_row, glyph_code, last     valid && ready
//   cfg      in         index (0 wrap_disabled, 1 columns, 2 rows), data   valid && ready
//
// A byte is taken every cycle while the operation queue has room; its operation is
// stored in the queue and its commands are then loaded into the output register.
// A byte that causes two commands holds the back end until its second command is
// loaded, so the back end takes no new operation before then.
// Reset is synchronous; there is no clearing pass.
// After a write to the rows register the back end reduces the cursor row and the
// scroll offset modulo the new row count by repeated subtraction, during which
// queued operations wait; bytes are still taken until the queue fills.
// A stalled command output stalls the back end, and the front end keeps taking
// bytes until the queue is full, so each side stalls on its own.
module terminal_escape_cursor_engine import tece_pkg::*; #(
  parameter int QUEUE_DEPTH = OP_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  tece_char_if.sink    chars,
  tece_cmd_if.source   cmds,
  tece_cfg_if.sink     cfg
);

  // Front end to queue.
  logic       push_valid, push_ready;
  op_t        push_op;

  // Queue to back end.
  logic       pop_valid, pop_ready;
  op_t        pop_op;

  // Back end to output port.
  result_t    out_res;
  cfg_write_t cfg_write;

  // Configuration writes are always taken; the registers sit in the back end.
  assign cfg.ready       = 1'b1;
  assign cfg_write.en    = cfg.valid;
  assign cfg_write.index = cfg.index;
  assign cfg_write.data  = cfg.data;

  // The front end classifies bytes and tracks the escape sequence and its numbers.
  tece_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chars.valid),
    .in_byte    (chars.char_byte),
    .in_ready   (chars.ready),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  // The queue decouples byte intake from command generation.
  tece_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  // The back end moves the cursor, scrolls and produces the display commands.
  tece_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .op_valid  (pop_valid),
    .op        (pop_op),
    .op_ready  (pop_ready),
    .out_valid (cmds.valid),
    .out_res   (out_res),
    .out_ready (cmds.ready)
  );

  assign cmds.action       = out_res.action;
  assign cmds.column       = out_res.column;
  assign cmds.physical_row = out_res.physical_row;
  assign cmds.glyph_code   = out_res.glyph_code;
  assign cmds.last         = out_res.last;

endmodule
